// ----- src/fpp_pkg.sv -----
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared types and constants for the framed signed pair parser.
// ----------------------------------------------------------------------------
package fpp_pkg;

    // frame buffer size in bytes; a body may hold at most BUFFER_BYTES-1 bytes
    localparam int BUFFER_BYTES = 16;
    localparam int CNT_W        = $clog2(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] BODY_LAST = CNT_W'(BUFFER_BYTES - 1);

    // framing and body characters
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // body parse phase
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ERR   = 2'd1,
        PH_DATA  = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    // one parsed frame
    typedef struct packed {
        logic signed [15:0] error_value;
        logic [7:0]         extra_data;
        logic               frame_valid;
        logic [15:0]        frame_number;
    } result_t;

endpackage

// ----- src/fpp_frame_parser.sv -----
// ----------------------------------------------------------------------------
// fpp_frame_parser
// Holds the frame and parse state and updates it for one byte per step.
// ----------------------------------------------------------------------------
module fpp_frame_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              emit,
    output fpp_pkg::result_t  result
);

    logic                       in_frame_reg,  in_frame_next;
    logic [fpp_pkg::CNT_W-1:0]  body_cnt_reg,  body_cnt_next;
    fpp_pkg::phase_t            phase_reg,     phase_next;
    logic                       negative_reg,  negative_next;
    logic [15:0]                err_acc_reg,   err_acc_next;
    logic [7:0]                 data_acc_reg,  data_acc_next;
    logic                       saw_digit_reg, saw_digit_next;
    logic                       saw_comma_reg, saw_comma_next;
    logic [15:0]                frame_cnt_reg, frame_cnt_next;

    logic        is_digit;
    logic [3:0]  digit_val;
    logic [15:0] err_times_ten;
    logic [7:0]  data_times_ten;

    // digit decode and multiply by ten as shift-add
    // ascii digits sit at 0x30..0x39, so the low nibble is the digit value
    assign is_digit       = rx_byte inside {[fpp_pkg::CHAR_ZERO:fpp_pkg::CHAR_NINE]};
    assign digit_val      = rx_byte[3:0];
    assign err_times_ten  = (err_acc_reg << 3) + (err_acc_reg << 1);
    assign data_times_ten = (data_acc_reg << 3) + (data_acc_reg << 1);

    // next state for framing and body parse
    always_comb begin
        in_frame_next  = in_frame_reg;
        body_cnt_next  = body_cnt_reg;
        phase_next     = phase_reg;
        negative_next  = negative_reg;
        err_acc_next   = err_acc_reg;
        data_acc_next  = data_acc_reg;
        saw_digit_next = saw_digit_reg;
        saw_comma_next = saw_comma_reg;
        frame_cnt_next = frame_cnt_reg;
        if (step) begin
            if (rx_byte == fpp_pkg::CHAR_DOLLAR) begin
                in_frame_next  = 1'b1;
                body_cnt_next  = '0;
                phase_next     = fpp_pkg::PH_START;
                negative_next  = 1'b0;
                err_acc_next   = '0;
                data_acc_next  = '0;
                saw_digit_next = 1'b0;
                saw_comma_next = 1'b0;
            end else if (rx_byte == fpp_pkg::CHAR_HASH) begin
                if (in_frame_reg) begin
                    frame_cnt_next = frame_cnt_reg + 16'd1;
                    in_frame_next  = 1'b0;
                end
            end else if (in_frame_reg) begin
                if (body_cnt_reg < fpp_pkg::BODY_LAST) begin
                    body_cnt_next = body_cnt_reg + 1'b1;
                    case (phase_reg)
                        fpp_pkg::PH_START: begin
                            if (rx_byte == fpp_pkg::CHAR_PLUS) begin
                                phase_next = fpp_pkg::PH_ERR;
                            end else if (rx_byte == fpp_pkg::CHAR_MINUS) begin
                                negative_next = 1'b1;
                                phase_next    = fpp_pkg::PH_ERR;
                            end else if (is_digit) begin
                                err_acc_next   = err_times_ten + {12'd0, digit_val};
                                saw_digit_next = 1'b1;
                                phase_next     = fpp_pkg::PH_ERR;
                            end else if (rx_byte == fpp_pkg::CHAR_COMMA) begin
                                saw_comma_next = 1'b1;
                                phase_next     = fpp_pkg::PH_DATA;
                            end else begin
                                phase_next = fpp_pkg::PH_STOP;
                            end
                        end
                        fpp_pkg::PH_ERR: begin
                            if (is_digit) begin
                                err_acc_next   = err_times_ten + {12'd0, digit_val};
                                saw_digit_next = 1'b1;
                            end else if (rx_byte == fpp_pkg::CHAR_COMMA) begin
                                saw_comma_next = 1'b1;
                                phase_next     = fpp_pkg::PH_DATA;
                            end else begin
                                phase_next = fpp_pkg::PH_STOP;
                            end
                        end
                        fpp_pkg::PH_DATA: begin
                            if (is_digit) begin
                                data_acc_next = data_times_ten + {4'd0, digit_val};
                            end else begin
                                phase_next = fpp_pkg::PH_STOP;
                            end
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end else begin
                    // overlong body drops the frame
                    in_frame_next = 1'b0;
                end
            end
        end
    end

    // result for a closing hash
    always_comb begin
        emit                = step && (rx_byte == fpp_pkg::CHAR_HASH) && in_frame_reg;
        result.error_value  = negative_reg ? $signed(16'd0 - err_acc_reg) : $signed(err_acc_reg);
        result.extra_data   = data_acc_reg;
        result.frame_valid  = saw_digit_reg && saw_comma_reg;
        result.frame_number = frame_cnt_reg + 16'd1;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg  <= 1'b0;
            body_cnt_reg  <= '0;
            phase_reg     <= fpp_pkg::PH_START;
            negative_reg  <= 1'b0;
            err_acc_reg   <= '0;
            data_acc_reg  <= '0;
            saw_digit_reg <= 1'b0;
            saw_comma_reg <= 1'b0;
            frame_cnt_reg <= '0;
        end else begin
            in_frame_reg  <= in_frame_next;
            body_cnt_reg  <= body_cnt_next;
            phase_reg     <= phase_next;
            negative_reg  <= negative_next;
            err_acc_reg   <= err_acc_next;
            data_acc_reg  <= data_acc_next;
            saw_digit_reg <= saw_digit_next;
            saw_comma_reg <= saw_comma_next;
            frame_cnt_reg <= frame_cnt_next;
        end
    end

endmodule

// ----- src/framed_signed_pair_parser.sv -----
// ----------------------------------------------------------------------------
// framed_signed_pair_parser
// Parses '$'[+|-]digits,digits'#' frames from a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_rx_byte carry one received byte per transfer.
//   m_valid/m_ready carry one result per closed frame: m_error_value,
//   m_extra_data, m_frame_valid, m_frame_number. Bytes that close no
//   frame produce no result transfer.
//   A byte is captured in an input register, then parsed against the held
//   frame state when it advances; a result lands in the output register,
//   which drives m_valid, so a closing byte passes the input register and
//   the output register before its result transfer.
//   Throughput is one byte per cycle while the output side takes results;
//   the parse step is combinational (one multiply by ten).
//   When m_valid is held by a stalled receiver, the input register stops
//   advancing and s_ready drops once it is full; bytes resume at once when
//   the result is taken.
//   Synchronous active-low reset clears frame state, the frame counter and
//   both valid flags.
// ----------------------------------------------------------------------------
module framed_signed_pair_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_error_value,
    output logic [7:0]         m_extra_data,
    output logic               m_frame_valid,
    output logic [15:0]        m_frame_number
);

    logic             byte_valid_reg;
    logic [7:0]       byte_reg;
    logic             out_valid_reg;
    fpp_pkg::result_t out_reg;
    logic             advance;
    logic             emit;
    fpp_pkg::result_t result;

    // input stage moves on when the output register can take a result
    assign advance = byte_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !byte_valid_reg || advance;

    fpp_frame_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (byte_reg),
        .emit    (emit),
        .result  (result)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg <= 1'b0;
        end else if (s_ready) begin
            byte_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && emit) begin
            out_reg <= result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_error_value  = out_reg.error_value;
    assign m_extra_data   = out_reg.extra_data;
    assign m_frame_valid  = out_reg.frame_valid;
    assign m_frame_number = out_reg.frame_number;

    // a result is only raised by a closing hash
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (byte_reg == fpp_pkg::CHAR_HASH))
        else $error("result raised by a byte other than hash");

    // an emitted result shows on the output in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> m_valid)
        else $error("emitted result not presented");

    // input side only stalls behind a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (byte_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a held result");

    // consecutive results carry consecutive frame numbers
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit && out_valid_reg) |=>
            (m_frame_number == $past(out_reg.frame_number) + 16'd1))
        else $error("frame number skipped");

endmodule
